>>> sv/qrs_pkg.sv
// qrs_pkg: widths, result class codes and the step functions of the quadratic solver
// used by quadratic_root_solver; depends on nothing
`default_nettype none
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int RES_FRAC  = 2 * FRAC_BITS;
    localparam int PROD_IN_W = 2 * COEF_W;
    localparam int D_W       = 34;
    localparam int ROOT_W    = 33;
    localparam int SUM_W     = 34;
    localparam int PROD_W    = 49;

    // square root of d in q16.16 scaled by another 2^16
    localparam int RAD_W     = 50;
    localparam int SQ_STEPS  = RAD_W / 2;
    localparam int S_W       = SQ_STEPS;
    localparam int SQ_REM_W  = S_W + 2;

    // division of the scaled numerators by |2a|
    localparam int NB_W      = COEF_W + FRAC_BITS + 1;
    localparam int DV_W      = COEF_W + 1;
    localparam int NUM_W     = NB_W + FRAC_BITS;
    localparam int DIV_STEPS = NUM_W;
    localparam int DREM_W    = DV_W;

    // split product of the root magnitudes
    localparam int PP_LO_W   = 17;
    localparam int PP_HI_W   = NUM_W - PP_LO_W;
    localparam int FULL_W    = 2 * NUM_W;
    localparam int P_W       = FULL_W - RES_FRAC;

    typedef enum logic [1:0] {
        CLS_TWO   = 2'd0,
        CLS_EQUAL = 2'd1,
        CLS_NONE  = 2'd2,
        CLS_DEGEN = 2'd3
    } t_cls;

    typedef struct packed {
        t_cls                    cls;
        logic signed [D_W-1:0]   d;
        logic                    a_neg;
        logic signed [NB_W-1:0]  nb;
        logic [DV_W-1:0]         dv;
    } t_meta;

    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [SQ_REM_W-1:0] rem;
        logic [S_W-1:0]      root;
    } t_sq;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DREM_W-1:0] rem;
    } t_dl;

    typedef struct packed {
        t_dl  p;
        t_dl  m;
        logic neg_p;
        logic neg_m;
    } t_dv;

    // one digit of the restoring square root
    function automatic t_sq sq_step(input t_sq x);
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        t_sq                 y;
        rem_sh = {x.rem[SQ_REM_W-3:0], x.rad[RAD_W-1 -: 2]};
        trial  = {x.root, 2'b01};
        y.rad  = {x.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            y.rem  = rem_sh - trial;
            y.root = {x.root[S_W-2:0], 1'b1};
        end else begin
            y.rem  = rem_sh;
            y.root = {x.root[S_W-2:0], 1'b0};
        end
        return y;
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_dl div_step(input t_dl l, input logic [DV_W-1:0] dv);
        logic [DREM_W:0] sh;
        logic [DREM_W:0] sub;
        t_dl             y;
        sh  = {l.rem, l.num[NUM_W-1]};
        sub = sh - {1'b0, dv};
        if (sh >= {1'b0, dv}) begin
            y.rem = sub[DREM_W-1:0];
            y.num = {l.num[NUM_W-2:0], 1'b1};
        end else begin
            y.rem = sh[DREM_W-1:0];
            y.num = {l.num[NUM_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage
`default_nettype wire

>>> sv/quadratic_root_solver.sv
// quadratic_root_solver: pipelined fixed-point solver for a*x^2 + b*x + c = 0
// depends on qrs_pkg (widths, class codes, square root and divider steps)
// throughput: one request per cycle unless the output stalls; set by the 25-stage
//   square root and the 33-stage dividers, each stage one digit
// reset: synchronous active-low i_rst_n clears all valid bits; data needs no reset
`default_nettype none
module quadratic_root_solver (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  signed [qrs_pkg::COEF_W-1:0]     i_coef_a,
    input  wire  signed [qrs_pkg::COEF_W-1:0]     i_coef_b,
    input  wire  signed [qrs_pkg::COEF_W-1:0]     i_coef_c,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [1:0]                            o_root_class,
    output logic signed [qrs_pkg::D_W-1:0]        o_discriminant,
    output logic signed [qrs_pkg::ROOT_W-1:0]     o_root_plus,
    output logic signed [qrs_pkg::ROOT_W-1:0]     o_root_minus,
    output logic signed [qrs_pkg::SUM_W-1:0]      o_root_sum,
    output logic signed [qrs_pkg::PROD_W-1:0]     o_root_product,
    output logic                                  o_overflow
);
    import qrs_pkg::*;

    // whole pipeline advances together; the output register holds while stalled
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // valid bits per section
    logic r_v_in, r_v_mul, r_v_root, r_v_pp, r_v_prod;
    logic r_sq_v [0:SQ_STEPS];
    logic r_dv_v [0:DIV_STEPS];

    // input register
    logic signed [COEF_W-1:0] r_a, r_b, r_c;

    // products
    logic signed [PROD_IN_W-1:0] r_bb, r_ac;
    logic signed [COEF_W-1:0]    r_a2, r_b2;

    // square root pipe, stage 0 holds the radicand
    t_sq   r_sq      [0:SQ_STEPS];
    t_meta r_sq_meta [0:SQ_STEPS];

    // divider pipe, stage 0 holds the numerator magnitudes
    t_dv   r_dv      [0:DIV_STEPS];
    t_meta r_dv_meta [0:DIV_STEPS];

    // signed, clamped roots and their sum
    logic signed [ROOT_W-1:0] r_xp, r_xm;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_ov;
    t_cls                     r_cls_r;
    logic signed [D_W-1:0]    r_d_r;

    // partial products
    logic [NUM_W+PP_LO_W-1:0] r_pp_lo;
    logic [NUM_W+PP_HI_W-1:0] r_pp_hi;
    logic                     r_neg_pp, r_ov_pp;
    logic signed [ROOT_W-1:0] r_xp_pp, r_xm_pp;
    logic signed [SUM_W-1:0]  r_sum_pp;
    t_cls                     r_cls_pp;
    logic signed [D_W-1:0]    r_d_pp;

    // rescaled product magnitude
    logic [P_W-1:0]           r_p;
    logic                     r_neg_pr, r_ov_pr;
    logic signed [ROOT_W-1:0] r_xp_pr, r_xm_pr;
    logic signed [SUM_W-1:0]  r_sum_pr;
    t_cls                     r_cls_pr;
    logic signed [D_W-1:0]    r_d_pr;

    // ---------------------------------------------------------------- valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in      <= 1'b0;
            r_v_mul     <= 1'b0;
            r_v_root    <= 1'b0;
            r_v_pp      <= 1'b0;
            r_v_prod    <= 1'b0;
            o_out_valid <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) r_sq_v[k] <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) r_dv_v[k] <= 1'b0;
        end else if (en) begin
            r_v_in    <= i_in_valid;
            r_v_mul   <= r_v_in;
            r_sq_v[0] <= r_v_mul;
            for (int k = 0; k < SQ_STEPS; k++) r_sq_v[k+1] <= r_sq_v[k];
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++) r_dv_v[k+1] <= r_dv_v[k];
            r_v_root    <= r_dv_v[DIV_STEPS];
            r_v_pp      <= r_v_root;
            r_v_prod    <= r_v_pp;
            o_out_valid <= r_v_prod;
        end
    end

    // ------------------------------------------- discriminant and its class
    logic signed [D_W-1:0]  n_d;
    logic [COEF_W-1:0]      n_abs_a;
    t_meta                  n_meta;
    t_sq                    n_sq0;

    always_comb begin
        n_d     = D_W'(r_bb) - (D_W'(r_ac) <<< 2);
        n_abs_a = r_a2[COEF_W-1] ? COEF_W'(-r_a2) : COEF_W'(r_a2);
        priority if (r_a2 == '0) n_meta.cls = CLS_DEGEN;
        else if (n_d < 0)        n_meta.cls = CLS_NONE;
        else if (n_d == '0)      n_meta.cls = CLS_EQUAL;
        else                     n_meta.cls = CLS_TWO;
        n_meta.d     = n_d;
        n_meta.a_neg = r_a2[COEF_W-1];
        n_meta.nb    = -(NB_W'(r_b2) <<< FRAC_BITS);
        n_meta.dv    = {n_abs_a, 1'b0};
        // d scaled by 2^16 so the root comes out in q16.16
        n_sq0.rad    = n_d[D_W-1] ? '0 : {n_d[RAD_W-RES_FRAC-1:0], {RES_FRAC{1'b0}}};
        n_sq0.rem    = '0;
        n_sq0.root   = '0;
    end

    // ------------------------------------------------------ numerator setup
    logic signed [NB_W:0] n_np, n_nm;
    logic [NB_W:0]        n_mp, n_mm;
    t_dv                  n_dv0;

    always_comb begin
        n_np = {r_sq_meta[SQ_STEPS].nb[NB_W-1], r_sq_meta[SQ_STEPS].nb}
             + {1'b0, r_sq[SQ_STEPS].root};
        n_nm = {r_sq_meta[SQ_STEPS].nb[NB_W-1], r_sq_meta[SQ_STEPS].nb}
             - {1'b0, r_sq[SQ_STEPS].root};
        n_mp = n_np[NB_W] ? (NB_W+1)'(-n_np) : (NB_W+1)'(n_np);
        n_mm = n_nm[NB_W] ? (NB_W+1)'(-n_nm) : (NB_W+1)'(n_nm);
        n_dv0.p.num = {n_mp[NB_W-1:0], {FRAC_BITS{1'b0}}};
        n_dv0.p.rem = '0;
        n_dv0.m.num = {n_mm[NB_W-1:0], {FRAC_BITS{1'b0}}};
        n_dv0.m.rem = '0;
        // quotient sign, truncated toward zero on the magnitude
        n_dv0.neg_p = n_np[NB_W] ^ r_sq_meta[SQ_STEPS].a_neg;
        n_dv0.neg_m = n_nm[NB_W] ^ r_sq_meta[SQ_STEPS].a_neg;
    end

    // ------------------------------------------- signed roots, clamp, sum
    logic signed [ROOT_W:0]   n_qp, n_qm;
    logic signed [ROOT_W-1:0] n_xp, n_xm;
    logic signed [SUM_W:0]    n_s;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     n_ov;
    localparam logic signed [ROOT_W-1:0] ROOT_HI = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic signed [ROOT_W-1:0] ROOT_LO = {1'b1, {(ROOT_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  SUM_HI  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_LO  = {1'b1, {(SUM_W-1){1'b0}}};

    always_comb begin
        n_ov = 1'b0;
        n_qp = r_dv[DIV_STEPS].neg_p ? -$signed({1'b0, r_dv[DIV_STEPS].p.num})
                                     :  $signed({1'b0, r_dv[DIV_STEPS].p.num});
        n_qm = r_dv[DIV_STEPS].neg_m ? -$signed({1'b0, r_dv[DIV_STEPS].m.num})
                                     :  $signed({1'b0, r_dv[DIV_STEPS].m.num});
        if (n_qp[ROOT_W] != n_qp[ROOT_W-1]) begin
            n_xp = n_qp[ROOT_W] ? ROOT_LO : ROOT_HI;
            n_ov = 1'b1;
        end else begin
            n_xp = n_qp[ROOT_W-1:0];
        end
        if (n_qm[ROOT_W] != n_qm[ROOT_W-1]) begin
            n_xm = n_qm[ROOT_W] ? ROOT_LO : ROOT_HI;
            n_ov = 1'b1;
        end else begin
            n_xm = n_qm[ROOT_W-1:0];
        end
        n_s = (SUM_W+1)'(n_xp) + (SUM_W+1)'(n_xm);
        if (n_s[SUM_W] != n_s[SUM_W-1]) begin
            n_sum = n_s[SUM_W] ? SUM_LO : SUM_HI;
            n_ov  = 1'b1;
        end else begin
            n_sum = n_s[SUM_W-1:0];
        end
    end

    // ------------------------------------------------ product magnitudes
    logic [NUM_W-1:0] n_ux, n_uy;
    always_comb begin
        n_ux = r_xp[ROOT_W-1] ? NUM_W'(-{1'b0, r_xp}) : NUM_W'(r_xp);
        n_uy = r_xm[ROOT_W-1] ? NUM_W'(-{1'b0, r_xm}) : NUM_W'(r_xm);
    end

    logic [FULL_W-1:0] n_full;
    assign n_full = FULL_W'(r_pp_lo) + (FULL_W'(r_pp_hi) << PP_LO_W);

    // ------------------------------------------------ product saturation
    logic [P_W-1:0]            n_limit, n_pm;
    logic                      n_ov_p;
    logic signed [PROD_W-1:0]  n_prod;
    always_comb begin
        n_limit = (P_W'(1) << (PROD_W-1)) - (r_neg_pr ? P_W'(0) : P_W'(1));
        n_ov_p  = r_p > n_limit;
        n_pm    = n_ov_p ? n_limit : r_p;
        n_prod  = r_neg_pr ? -$signed(n_pm[PROD_W-1:0]) : $signed(n_pm[PROD_W-1:0]);
    end

    logic n_zero;
    assign n_zero = (r_cls_pr == CLS_NONE) || (r_cls_pr == CLS_DEGEN);

    // ---------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= i_coef_a;
            r_b <= i_coef_b;
            r_c <= i_coef_c;

            r_bb <= r_b * r_b;
            r_ac <= r_a * r_c;
            r_a2 <= r_a;
            r_b2 <= r_b;

            r_sq[0]      <= n_sq0;
            r_sq_meta[0] <= n_meta;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq[k+1]      <= sq_step(r_sq[k]);
                r_sq_meta[k+1] <= r_sq_meta[k];
            end

            r_dv[0]      <= n_dv0;
            r_dv_meta[0] <= r_sq_meta[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv[k+1].p     <= div_step(r_dv[k].p, r_dv_meta[k].dv);
                r_dv[k+1].m     <= div_step(r_dv[k].m, r_dv_meta[k].dv);
                r_dv[k+1].neg_p <= r_dv[k].neg_p;
                r_dv[k+1].neg_m <= r_dv[k].neg_m;
                r_dv_meta[k+1]  <= r_dv_meta[k];
            end

            r_xp    <= n_xp;
            r_xm    <= n_xm;
            r_sum   <= n_sum;
            r_ov    <= n_ov;
            r_cls_r <= r_dv_meta[DIV_STEPS].cls;
            r_d_r   <= r_dv_meta[DIV_STEPS].d;

            r_pp_lo  <= n_ux * n_uy[PP_LO_W-1:0];
            r_pp_hi  <= n_ux * n_uy[NUM_W-1:PP_LO_W];
            r_neg_pp <= r_xp[ROOT_W-1] ^ r_xm[ROOT_W-1];
            r_ov_pp  <= r_ov;
            r_xp_pp  <= r_xp;
            r_xm_pp  <= r_xm;
            r_sum_pp <= r_sum;
            r_cls_pp <= r_cls_r;
            r_d_pp   <= r_d_r;

            r_p      <= n_full[FULL_W-1:RES_FRAC];
            r_neg_pr <= r_neg_pp;
            r_ov_pr  <= r_ov_pp;
            r_xp_pr  <= r_xp_pp;
            r_xm_pr  <= r_xm_pp;
            r_sum_pr <= r_sum_pp;
            r_cls_pr <= r_cls_pp;
            r_d_pr   <= r_d_pp;

            // no real roots or a degenerate equation: zero results, no overflow
            o_root_class   <= r_cls_pr;
            o_discriminant <= r_d_pr;
            o_root_plus    <= n_zero ? '0 : r_xp_pr;
            o_root_minus   <= n_zero ? '0 : r_xm_pr;
            o_root_sum     <= n_zero ? '0 : r_sum_pr;
            o_root_product <= n_zero ? '0 : n_prod;
            o_overflow     <= n_zero ? 1'b0 : (r_ov_pr || n_ov_p);
        end
    end

`ifndef SYNTHESIS
    a_ready_follows_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_zero_when_no_roots : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_root_class == CLS_NONE || o_root_class == CLS_DEGEN)
        |-> o_root_plus == '0 && o_root_minus == '0 && o_root_product == '0 && !o_overflow)
        else $error("nonzero result for a class without roots");

    a_equal_roots : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_class == CLS_EQUAL
        |-> o_discriminant == '0 && o_root_plus == o_root_minus)
        else $error("equal roots class with unequal roots");

    a_none_negative : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_class == CLS_NONE |-> o_discriminant < 0)
        else $error("no real roots class with nonnegative discriminant");
`endif

endmodule
`default_nettype wire

>>> tb/quadratic_root_solver_tb.sv
// quadratic_root_solver_tb: self-checking testbench for the fixed-point quadratic solver
// depends on qrs_pkg and quadratic_root_solver; predicts every result in a local function
`timescale 1ns / 1ps
module quadratic_root_solver_tb;
    import qrs_pkg::*;

    // one expected solver result, fields at the port widths
    typedef struct {
        t_cls                      cls;
        logic signed [D_W-1:0]     disc;
        logic signed [ROOT_W-1:0]  rp;
        logic signed [ROOT_W-1:0]  rm;
        logic signed [SUM_W-1:0]   rsum;
        logic signed [PROD_W-1:0]  rprod;
        logic                      ovf;
    } t_solution;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [COEF_W-1:0]  i_coef_a = '0;
    logic signed [COEF_W-1:0]  i_coef_b = '0;
    logic signed [COEF_W-1:0]  i_coef_c = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_root_class;
    logic signed [D_W-1:0]     o_discriminant;
    logic signed [ROOT_W-1:0]  o_root_plus;
    logic signed [ROOT_W-1:0]  o_root_minus;
    logic signed [SUM_W-1:0]   o_root_sum;
    logic signed [PROD_W-1:0]  o_root_product;
    logic                      o_overflow;

    t_solution pending_solutions[$];
    int        mismatches = 0;
    int        stall_request = 0;   // long receiver hold-off asked by a test
    bit        rx_enable = 1'b0;

    quadratic_root_solver uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_coef_a(i_coef_a), .i_coef_b(i_coef_b), .i_coef_c(i_coef_c),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_root_class(o_root_class), .o_discriminant(o_discriminant),
        .o_root_plus(o_root_plus), .o_root_minus(o_root_minus),
        .o_root_sum(o_root_sum), .o_root_product(o_root_product),
        .o_overflow(o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // saturate a signed value to a field of w bits
    function automatic longint sat_to(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // bit-exact prediction of one coefficient set
    function automatic t_solution solve_quadratic(logic signed [COEF_W-1:0] a,
                                                  logic signed [COEF_W-1:0] b,
                                                  logic signed [COEF_W-1:0] c);
        t_solution          res;
        longint             sa, sb, sc, d, dc, s, nb, den, xp, xm, t, sum, prod;
        longint unsigned    n, r, bt, ux, uy, lim, p;
        bit                 ov;
        bit                 neg;
        sa = a; sb = b; sc = c;
        d = sb * sb - 4 * sa * sc;
        xp = 0; xm = 0; sum = 0; prod = 0; ov = 0;
        if (sa == 0) begin
            res.cls = CLS_DEGEN;
        end else if (d < 0) begin
            res.cls = CLS_NONE;
        end else begin
            // floored square root of d scaled by 2^16, digit by digit
            n = longint'(d) << RES_FRAC;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > n) bt = bt >> 2;
            while (bt != 0) begin
                if (n >= r + bt) begin
                    n = n - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
            s = longint'(r);
            nb = -sb * (longint'(1) <<< FRAC_BITS);
            den = 2 * sa;
            res.cls = (d > 0) ? CLS_TWO : CLS_EQUAL;
            xp = ((nb + s) * (longint'(1) <<< FRAC_BITS)) / den;
            xm = ((nb - s) * (longint'(1) <<< FRAC_BITS)) / den;
            t = sat_to(xp, ROOT_W); if (t != xp) ov = 1; xp = t;
            t = sat_to(xm, ROOT_W); if (t != xm) ov = 1; xm = t;
            sum = sat_to(xp + xm, SUM_W); if (sum != xp + xm) ov = 1;
            // magnitude product, truncated to q16.16, then saturated
            neg = (xp < 0) != (xm < 0);
            ux = (xp < 0) ? longint'(-xp) : longint'(xp);
            uy = (xm < 0) ? longint'(-xm) : longint'(xm);
            lim = (64'd1 << 48) - (neg ? 64'd0 : 64'd1);
            if (uy != 0 && ux > 64'hFFFF_FFFF_FFFF_FFFF / uy) begin
                p = lim; ov = 1;
            end else begin
                p = (ux * uy) >> RES_FRAC;
                if (p > lim) begin
                    p = lim; ov = 1;
                end
            end
            prod = neg ? -longint'(p) : longint'(p);
        end
        dc = sat_to(d, D_W); if (dc != d) ov = 1;
        res.disc  = dc[D_W-1:0];
        res.rp    = xp[ROOT_W-1:0];
        res.rm    = xm[ROOT_W-1:0];
        res.rsum  = sum[SUM_W-1:0];
        res.rprod = prod[PROD_W-1:0];
        res.ovf   = ov;
        return res;
    endfunction

    // offer one request after a gap; valid stays high when the gap is zero
    task automatic send_coefs(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                              logic signed [COEF_W-1:0] c, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        do @(posedge i_clk); while (!o_in_ready);
        pending_solutions.push_back(solve_quadratic(a, b, c));
    endtask

    task automatic send_rand_gap(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                                 logic signed [COEF_W-1:0] c);
        // at least a third of requests come back to back
        send_coefs(a, b, c, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8));
    endtask

    // result checker; receiver takes a test's hold-off, else draws its own stall
    initial begin : result_checker
        t_solution exp_sol;
        int        w;
        wait (rx_enable);
        forever begin
            if (stall_request > 0) begin
                w = stall_request;
                stall_request = 0;
            end else begin
                w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_solutions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: class %0d disc %0d", o_root_class,
                             o_discriminant);
            end else begin
                exp_sol = pending_solutions.pop_front();
                if (o_root_class !== exp_sol.cls || o_discriminant !== exp_sol.disc ||
                    o_root_plus !== exp_sol.rp || o_root_minus !== exp_sol.rm ||
                    o_root_sum !== exp_sol.rsum || o_root_product !== exp_sol.rprod ||
                    o_overflow !== exp_sol.ovf) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("exp: cls %0d d %0d rp %0d rm %0d sum %0d prod %0d ov %0d",
                                 exp_sol.cls, exp_sol.disc, exp_sol.rp, exp_sol.rm,
                                 exp_sol.rsum, exp_sol.rprod, exp_sol.ovf);
                        $display("got: cls %0d d %0d rp %0d rm %0d sum %0d prod %0d ov %0d",
                                 o_root_class, o_discriminant, o_root_plus, o_root_minus,
                                 o_root_sum, o_root_product, o_overflow);
                    end
                end
            end
        end
    end

    // extremes, each class, and saturating cases
    task automatic test_directed();
        send_coefs(16'sh0000, 16'sh0000, 16'sh0000, 0);   // degenerate, all zero
        send_coefs(16'sh0000, 16'sh7FFF, -16'sh8000, 1);  // degenerate with nonzero d
        send_coefs(16'sh0100, 16'sh0000, -16'sh0400, 0);  // x^2 - 4: two roots
        send_coefs(16'sh0100, -16'sh0200, 16'sh0100, 0);  // (x-1)^2: equal roots
        send_coefs(16'sh0100, 16'sh0000, 16'sh0100, 2);   // x^2 + 1: no real roots
        send_coefs(16'sh0001, 16'sh7FFF, 16'sh0000, 0);   // tiny a, one very large root
        send_coefs(16'sh0001, -16'sh8000, 16'sh0000, 0);
        send_coefs(-16'sh0001, -16'sh8000, 16'sh7FFF, 0);
        send_coefs(16'sh0001, 16'sh0000, -16'sh8000, 3);
        send_coefs(-16'sh8000, 16'sh0000, 16'sh7FFF, 0);  // large d from a and c alone
        send_coefs(-16'sh8000, -16'sh8000, 16'sh7FFF, 0);
        send_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_coefs(-16'sh8000, -16'sh8000, -16'sh8000, 0);
        send_coefs(16'sh7FFF, -16'sh8000, -16'sh8000, 0);
        send_coefs(-16'sh0100, 16'sh0300, -16'sh0200, 1); // negative a, two roots
        send_coefs(16'sh0200, 16'sh0000, 16'sh0000, 0);   // equal roots at zero
        send_coefs(16'sh0003, 16'sh0007, -16'sh0005, 0);  // odd truncation
        send_coefs(-16'sh0003, 16'sh0007, 16'sh0005, 0);
        send_coefs(16'shFFFF, 16'shFFFF, 16'shFFFF, 4);
    endtask

    // random coefficients, half of them shaped to hit every class
    task automatic test_random(int count);
        int                        kind, s, u, v;
        logic signed [COEF_W-1:0]  a, b, c;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            a = COEF_W'($urandom); b = COEF_W'($urandom); c = COEF_W'($urandom);
            case (kind)
                0: a = '0;
                1, 2: begin
                    // exact square: b^2 == 4ac
                    s = ($urandom_range(0, 1) == 0) ? 1 : -1;
                    u = $urandom_range(1, 60);
                    v = $urandom_range(0, 60);
                    a = COEF_W'(s * u * u);
                    c = COEF_W'(s * v * v);
                    b = COEF_W'((($urandom_range(0, 1) == 0) ? 2 : -2) * s * u * v);
                end
                3, 4: begin
                    // small magnitudes, roots within range
                    a = COEF_W'(int'($urandom_range(1, 2047)) *
                                (($urandom_range(0, 1) == 0) ? 1 : -1));
                    b = COEF_W'(int'($urandom_range(0, 4095)) - 2048);
                    c = COEF_W'(int'($urandom_range(0, 4095)) - 2048);
                end
                default: ;
            endcase
            send_rand_gap(a, b, c);
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        stall_request = 400;
        repeat (200) send_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom), 0);
    endtask

    initial begin : run_tests
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_enable = 1'b1;
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(730);
        i_in_valid <= 1'b0;
        wait (pending_solutions.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_solutions.size() == 0)
            $display("quadratic_root_solver_tb: done, clean");
        else
            $display("quadratic_root_solver_tb: done, errors");
        $finish;
    end

    initial begin : run_limit
        #5ms;
        $display("quadratic_root_solver_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/qrs_pkg.sv
sv/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
